// File: sv/prs_pkg.sv
`timescale 1ns / 1ps
package prs_pkg;

    // Widths fixed by the beat fields.
    localparam int MOD_FIELD_W  = 32;
    localparam int ROOT_FIELD_W = 32;

    // Defaults for the top-level parameters.
    localparam int MODULUS_BITS_DEF = 32;
    localparam int MAX_FACTORS_DEF  = 9;

    // Operation codes of the shared arithmetic unit.
    typedef logic arith_op_t;
    localparam arith_op_t OP_DIV = 1'b0;
    localparam arith_op_t OP_MUL = 1'b1;

    // Request from the sequencer to the arithmetic unit.
    typedef struct packed {
        logic      start;
        arith_op_t op;
    } arith_req_t;

endpackage

// File: sv/prs_arith.sv
`timescale 1ns / 1ps
module prs_arith #(
    parameter int N = prs_pkg::MODULUS_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  prs_pkg::arith_req_t req,
    input  logic [N-1:0]        opa,
    input  logic [N-1:0]        opb,
    input  logic [N-1:0]        modulus,
    output logic [N-1:0]        res_q,
    output logic [N-1:0]        res_r,
    output logic                done
);
    import prs_pkg::*;

    localparam int CNW = $clog2(N + 1);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    arith_op_t       op_reg, op_next;
    logic [CNW-1:0]  cnt_reg, cnt_next;
    logic [N-1:0]    sh_reg, sh_next;
    logic [N-1:0]    acc_reg, acc_next;
    logic [N-1:0]    x_reg, x_next;
    logic [N-1:0]    d_reg, d_next;

    // Division step: shift one dividend bit into the partial remainder.
    logic [N:0]   r2;
    logic         ge;
    logic [N:0]   r2_sub;
    // Multiplication step: double, then add x when the multiplier bit is set.
    logic [N:0]   s1, s1_sub, s2, s2_sub;
    logic [N-1:0] t1, t2;

    always_comb begin
        r2     = {acc_reg, sh_reg[N-1]};
        ge     = r2 >= {1'b0, d_reg};
        r2_sub = r2 - {1'b0, d_reg};
        s1     = {1'b0, acc_reg} + {1'b0, acc_reg};
        s1_sub = s1 - {1'b0, d_reg};
        t1     = (s1 >= {1'b0, d_reg}) ? s1_sub[N-1:0] : s1[N-1:0];
        s2     = {1'b0, t1} + {1'b0, x_reg};
        s2_sub = s2 - {1'b0, d_reg};
        t2     = (s2 >= {1'b0, d_reg}) ? s2_sub[N-1:0] : s2[N-1:0];
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        sh_next   = sh_reg;
        acc_next  = acc_reg;
        x_next    = x_reg;
        d_next    = d_reg;
        if (req.start) begin
            busy_next = 1'b1;
            op_next   = req.op;
            cnt_next  = CNW'(N);
            sh_next   = (req.op == OP_MUL) ? opb : opa;
            x_next    = opa;
            d_next    = (req.op == OP_MUL) ? modulus : opb;
            acc_next  = '0;
        end else if (busy_reg) begin
            unique case (op_reg)
                OP_DIV: begin
                    acc_next = ge ? r2_sub[N-1:0] : r2[N-1:0];
                    sh_next  = {sh_reg[N-2:0], ge};
                end
                OP_MUL: begin
                    acc_next = sh_reg[N-1] ? t2 : t1;
                    sh_next  = {sh_reg[N-2:0], 1'b0};
                end
                default: begin
                    acc_next = acc_reg;
                end
            endcase
            cnt_next = cnt_reg - CNW'(1);
            if (cnt_reg == CNW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= OP_DIV;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            op_reg   <= op_next;
        end
        sh_reg  <= sh_next;
        acc_reg <= acc_next;
        x_reg   <= x_next;
        d_reg   <= d_next;
    end

    assign res_q = (op_reg == OP_DIV) ? sh_reg : acc_reg;
    assign res_r = acc_reg;
    assign done  = done_reg;

`ifndef NO_ASSERTIONS
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("result flagged while the unit is still busy");
    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> !busy_reg)
        else $error("new request while an operation is running");
    a_acc_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && !$past(req.start) |-> acc_reg < d_reg)
        else $error("partial result not reduced below the modulus or divisor");
`endif

endmodule

// File: sv/primitive_root_search.sv
`timescale 1ns / 1ps
// Channel  | Direction | Ports                       | Meaning
// s_       | in        | s_valid s_ready s_modulus   | prime modulus p
// m_       | out       | m_valid m_ready m_root m_found | smallest primitive root
//
// One beat factors p-1 by trial division, then computes one modular power per
// factor tried for each candidate; every division and multiplication runs on
// the one shared bit-serial divide/multiply unit.
// Reset (synchronous, active low) returns the sequencer to idle and drops m_valid.
// A new beat is taken while a finished result still waits on m_ready.
module primitive_root_search #(
    parameter int MODULUS_BITS = prs_pkg::MODULUS_BITS_DEF,
    parameter int MAX_FACTORS  = prs_pkg::MAX_FACTORS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [prs_pkg::MOD_FIELD_W-1:0]    s_modulus,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [prs_pkg::ROOT_FIELD_W-1:0]   m_root,
    output logic                               m_found
);
    import prs_pkg::*;

    localparam int N  = MODULUS_BITS;
    localparam int EW = (N > MOD_FIELD_W) ? N : MOD_FIELD_W;
    localparam int KW = (MAX_FACTORS > 1) ? $clog2(MAX_FACTORS) : 1;
    localparam int CW = $clog2(MAX_FACTORS + 1);

    // Sequencer states.
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FDIV  = 4'd1;
    localparam logic [3:0] S_TAIL  = 4'd2;
    localparam logic [3:0] S_EXPI  = 4'd3;
    localparam logic [3:0] S_EDIV  = 4'd4;
    localparam logic [3:0] S_GINIT = 4'd5;
    localparam logic [3:0] S_PSTEP = 4'd6;
    localparam logic [3:0] S_PMUL1 = 4'd7;
    localparam logic [3:0] S_PMUL2 = 4'd8;
    localparam logic [3:0] S_PCHK  = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    logic [3:0]   state_reg, state_next;
    logic [N-1:0] p_reg, p_next;
    logic [N-1:0] rest_reg, rest_next;
    logic [N-1:0] d_reg, d_next;
    logic         inner_reg, inner_next;
    logic [CW-1:0] fcnt_reg, fcnt_next;
    logic [CW-1:0] k_reg, k_next;
    logic [N-1:0] g_reg, g_next;
    logic [N-1:0] e_reg, e_next;
    logic [N-1:0] pacc_reg, pacc_next;
    logic [N-1:0] base_reg, base_next;
    logic         found_reg, found_next;
    logic [N-1:0] root_reg, root_next;

    logic                    m_valid_reg, m_valid_next;
    logic [ROOT_FIELD_W-1:0] m_root_reg, m_root_next;
    logic                    m_found_reg, m_found_next;

    // Factor table. After factoring, each entry is replaced by (p-1)/q.
    logic [N-1:0] fac_reg [MAX_FACTORS];
    logic         fac_we;
    logic [KW-1:0] fac_wa;
    logic [N-1:0] fac_wd;
    logic [N-1:0] fac_rd;

    // Request registers of the arithmetic unit.
    arith_req_t   ar_req_reg, ar_req_next;
    logic [N-1:0] ar_a_reg, ar_a_next;
    logic [N-1:0] ar_b_reg, ar_b_next;
    logic [N-1:0] ar_q, ar_r;
    logic         ar_done;

    logic [EW-1:0] mod_ext;
    logic [N-1:0]  p_in;
    logic [EW-1:0] root_ext;
    logic [N-1:0]  phi;
    logic [N-1:0]  d_inc;

    assign mod_ext = EW'(s_modulus);
    assign p_in    = mod_ext[N-1:0];
    assign root_ext = EW'(root_reg);
    assign phi     = p_reg - N'(1);
    assign d_inc   = d_reg + N'(1);
    assign fac_rd  = fac_reg[k_reg[KW-1:0]];

    prs_arith #(.N(N)) u_arith (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (ar_req_reg),
        .opa     (ar_a_reg),
        .opb     (ar_b_reg),
        .modulus (p_reg),
        .res_q   (ar_q),
        .res_r   (ar_r),
        .done    (ar_done)
    );

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next   = state_reg;
        p_next       = p_reg;
        rest_next    = rest_reg;
        d_next       = d_reg;
        inner_next   = inner_reg;
        fcnt_next    = fcnt_reg;
        k_next       = k_reg;
        g_next       = g_reg;
        e_next       = e_reg;
        pacc_next    = pacc_reg;
        base_next    = base_reg;
        found_next   = found_reg;
        root_next    = root_reg;
        m_valid_next = m_valid_reg;
        m_root_next  = m_root_reg;
        m_found_next = m_found_reg;
        ar_req_next  = '{start: 1'b0, op: OP_DIV};
        ar_a_next    = ar_a_reg;
        ar_b_next    = ar_b_reg;
        fac_we       = 1'b0;
        fac_wa       = fcnt_reg[KW-1:0];
        fac_wd       = d_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    p_next = p_in;
                    if (p_in < N'(2)) begin
                        found_next = 1'b0;
                        root_next  = '0;
                        state_next = S_OUT;
                    end else begin
                        // Trial division of p-1 starts with divisor two.
                        rest_next   = p_in - N'(1);
                        d_next      = N'(2);
                        inner_next  = 1'b0;
                        fcnt_next   = '0;
                        ar_req_next = '{start: 1'b1, op: OP_DIV};
                        ar_a_next   = p_in - N'(1);
                        ar_b_next   = N'(2);
                        state_next  = S_FDIV;
                    end
                end
            end
            S_FDIV: begin
                if (ar_done) begin
                    if (inner_reg) begin
                        // Strip every power of the current factor.
                        if (ar_r == '0) begin
                            rest_next   = ar_q;
                            ar_req_next = '{start: 1'b1, op: OP_DIV};
                            ar_a_next   = ar_q;
                            ar_b_next   = d_reg;
                        end else begin
                            inner_next  = 1'b0;
                            d_next      = d_inc;
                            ar_req_next = '{start: 1'b1, op: OP_DIV};
                            ar_a_next   = rest_reg;
                            ar_b_next   = d_inc;
                        end
                    end else if (ar_q < d_reg) begin
                        state_next = S_TAIL;
                    end else if (ar_r != '0) begin
                        d_next      = d_inc;
                        ar_req_next = '{start: 1'b1, op: OP_DIV};
                        ar_a_next   = rest_reg;
                        ar_b_next   = d_inc;
                    end else begin
                        if (fcnt_reg < CW'(MAX_FACTORS)) begin
                            fac_we    = 1'b1;
                            fac_wd    = d_reg;
                            fcnt_next = fcnt_reg + CW'(1);
                        end
                        inner_next  = 1'b1;
                        rest_next   = ar_q;
                        ar_req_next = '{start: 1'b1, op: OP_DIV};
                        ar_a_next   = ar_q;
                        ar_b_next   = d_reg;
                    end
                end
            end
            S_TAIL: begin
                // What is left above one is the last prime factor.
                if (rest_reg > N'(1) && fcnt_reg < CW'(MAX_FACTORS)) begin
                    fac_we    = 1'b1;
                    fac_wd    = rest_reg;
                    fcnt_next = fcnt_reg + CW'(1);
                end
                k_next     = '0;
                state_next = S_EXPI;
            end
            S_EXPI: begin
                if (k_reg == fcnt_reg) begin
                    g_next     = N'(2);
                    k_next     = '0;
                    state_next = S_GINIT;
                end else begin
                    ar_req_next = '{start: 1'b1, op: OP_DIV};
                    ar_a_next   = phi;
                    ar_b_next   = fac_rd;
                    state_next  = S_EDIV;
                end
            end
            S_EDIV: begin
                if (ar_done) begin
                    fac_we     = 1'b1;
                    fac_wa     = k_reg[KW-1:0];
                    fac_wd     = ar_q;
                    k_next     = k_reg + CW'(1);
                    state_next = S_EXPI;
                end
            end
            S_GINIT: begin
                if (k_reg == fcnt_reg) begin
                    found_next = 1'b1;
                    root_next  = g_reg;
                    state_next = S_OUT;
                end else begin
                    e_next     = fac_rd;
                    pacc_next  = N'(1);
                    base_next  = (g_reg == p_reg) ? '0 : g_reg;
                    state_next = S_PSTEP;
                end
            end
            S_PSTEP: begin
                if (e_reg == '0) begin
                    state_next = S_PCHK;
                end else if (e_reg[0]) begin
                    ar_req_next = '{start: 1'b1, op: OP_MUL};
                    ar_a_next   = pacc_reg;
                    ar_b_next   = base_reg;
                    state_next  = S_PMUL1;
                end else begin
                    ar_req_next = '{start: 1'b1, op: OP_MUL};
                    ar_a_next   = base_reg;
                    ar_b_next   = base_reg;
                    state_next  = S_PMUL2;
                end
            end
            S_PMUL1: begin
                if (ar_done) begin
                    pacc_next   = ar_q;
                    ar_req_next = '{start: 1'b1, op: OP_MUL};
                    ar_a_next   = base_reg;
                    ar_b_next   = base_reg;
                    state_next  = S_PMUL2;
                end
            end
            S_PMUL2: begin
                if (ar_done) begin
                    base_next  = ar_q;
                    e_next     = {1'b0, e_reg[N-1:1]};
                    state_next = S_PSTEP;
                end
            end
            S_PCHK: begin
                if (pacc_reg == N'(1)) begin
                    if (g_reg >= p_reg) begin
                        found_next = 1'b0;
                        root_next  = '0;
                        state_next = S_OUT;
                    end else begin
                        g_next     = g_reg + N'(1);
                        k_next     = '0;
                        state_next = S_GINIT;
                    end
                end else begin
                    k_next     = k_reg + CW'(1);
                    state_next = S_GINIT;
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_root_next  = root_ext[ROOT_FIELD_W-1:0];
                    m_found_next = found_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            ar_req_reg  <= '{start: 1'b0, op: OP_DIV};
            fcnt_reg    <= '0;
            k_reg       <= '0;
            inner_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            ar_req_reg  <= ar_req_next;
            fcnt_reg    <= fcnt_next;
            k_reg       <= k_next;
            inner_reg   <= inner_next;
        end
        p_reg       <= p_next;
        rest_reg    <= rest_next;
        d_reg       <= d_next;
        g_reg       <= g_next;
        e_reg       <= e_next;
        pacc_reg    <= pacc_next;
        base_reg    <= base_next;
        found_reg   <= found_next;
        root_reg    <= root_next;
        m_root_reg  <= m_root_next;
        m_found_reg <= m_found_next;
        ar_a_reg    <= ar_a_next;
        ar_b_reg    <= ar_b_next;
    end

    always_ff @(posedge aclk) begin
        if (fac_we) begin
            fac_reg[fac_wa] <= fac_wd;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_root  = m_root_reg;
    assign m_found = m_found_reg;

`ifndef NO_ASSERTIONS
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_found_reg |-> m_root_reg == '0)
        else $error("failure beat carries a nonzero root");
    a_fcnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fcnt_reg <= CW'(MAX_FACTORS))
        else $error("factor count beyond table size");
    a_div_trial: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_FDIV |-> d_reg >= N'(2))
        else $error("trial divisor below two");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |=> m_valid_reg && $stable(m_root_reg))
        else $error("pending result overwritten");
`endif

endmodule
